### rtl/core/sctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctd_pkg
// Constants and types for the seconds-to-calendar conversion pipeline.
// ----------------------------------------------------------------------------
package sctd_pkg;

  // seconds / 86400 = (seconds >> 7) / 675
  localparam int unsigned DaySplitShift = 7;
  localparam int unsigned DayOdd        = 675;
  // floor(2^32 / 675); estimate is low by at most one, fixed by a compare
  localparam int unsigned DayRecip      = 6362914;
  localparam int unsigned DayRecipShift = 32;

  // v / 60 = (v * ceil(2^23 / 60)) >> 23, exact for v < 86400
  localparam int unsigned MinRecip      = 139811;
  localparam int unsigned MinRecipShift = 23;
  localparam int unsigned SecPerMin     = 60;

  // century term: jc - 6680 = (4*days + 37747) / 1461
  localparam int unsigned CentBias      = 37747;
  // ceil(2^28 / 1461), exact for numerators below 194000
  localparam int unsigned CentRecip     = 183735;
  localparam int unsigned CentShift     = 28;

  // jb - jd = days + 9559 - 365*q - q/4
  localparam int unsigned DayOfYrBias   = 9559;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned YearBase      = 1965;

  // floor(30.6001 * e) for e = 0..16
  localparam logic [8:0] MonOff [17] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
    9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
  };

  // per-stage load enables for the date path
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } date_ld_t;

endpackage

### rtl/core/seconds_to_calendar_datetime_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime_core
// Seconds since 1989-12-31 00:00:00 to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Fully pipelined converter: one timestamp is accepted per clock while ready_o
// is high, and results leave in input order through seven register stages
// (day split by reciprocal multiply, remainder correction, then the
// minute/hour and century/month reciprocal steps). Each stage holds its own
// valid bit and loads whenever it is empty or the stage after it moves, so a
// stalled output only blocks the input once every stage is occupied, and
// empty slots are squeezed out.
module seconds_to_calendar_datetime_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [30:0] elapsed_seconds_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);
  import sctd_pkg::*;

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   rdy;

  logic [23:0] x1_q;
  logic [46:0] day_prod_q;
  logic [6:0]  lo1_q;

  logic [14:0] q0;
  logic [23:0] r0_full;
  logic [14:0] q2_q;
  logic [10:0] r2_q;
  logic [6:0]  lo2_q;

  logic        r_over;
  logic [10:0] r_fix;
  logic [14:0] days3_q;
  logic [16:0] rem3_q;

  logic [33:0] min_prod_q;
  logic [16:0] rem4_q;

  logic [10:0] mt5;
  logic [16:0] sec_full;
  logic [10:0] mt5_q;
  logic [5:0]  sec5_q;

  logic [28:0] hr_prod_q;
  logic [10:0] mt6_q;
  logic [5:0]  sec6_q;

  logic [4:0]  hr7;
  logic [10:0] min_full;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  date_ld_t    date_ld;

  // per-stage ready chain
  assign rdy[NumStages] = ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: day estimate by reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x1_q       <= elapsed_seconds_i[30:DaySplitShift];
      lo1_q      <= elapsed_seconds_i[DaySplitShift-1:0];
      day_prod_q <= 47'(elapsed_seconds_i[30:DaySplitShift]) * 47'(DayRecip);
    end
  end

  // stage 2: remainder of the estimate, below 2*675
  assign q0      = day_prod_q[DayRecipShift +: 15];
  assign r0_full = x1_q - 24'(q0) * 24'(DayOdd);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      q2_q  <= q0;
      r2_q  <= r0_full[10:0];
      lo2_q <= lo1_q;
    end
  end

  // stage 3: correct the estimate by one where needed
  assign r_over = (r2_q >= 11'(DayOdd));
  assign r_fix  = r_over ? (r2_q - 11'(DayOdd)) : r2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      days3_q <= q2_q + (r_over ? 15'd1 : 15'd0);
      rem3_q  <= {r_fix[9:0], lo2_q};
    end
  end

  // stage 4: total minutes multiply
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      min_prod_q <= 34'(rem3_q) * 34'(MinRecip);
      rem4_q     <= rem3_q;
    end
  end

  // stage 5: seconds
  assign mt5      = min_prod_q[MinRecipShift +: 11];
  assign sec_full = rem4_q - 17'(mt5) * 17'(SecPerMin);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      mt5_q  <= mt5;
      sec5_q <= sec_full[5:0];
    end
  end

  // stage 6: hours multiply
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      hr_prod_q <= 29'(mt5_q) * 29'(MinRecip);
      mt6_q     <= mt5_q;
      sec6_q    <= sec5_q;
    end
  end

  // stage 7: hour and minute, output register
  assign hr7      = hr_prod_q[MinRecipShift +: 5];
  assign min_full = mt6_q - 11'(hr7) * 11'(SecPerMin);

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      hour_q   <= hr7;
      minute_q <= min_full[5:0];
      second_q <= sec6_q;
    end
  end

  assign date_ld.s4 = rdy[3];
  assign date_ld.s5 = rdy[4];
  assign date_ld.s6 = rdy[5];
  assign date_ld.s7 = rdy[6];

  sctd_date u_date (
    .clk_i          (clk_i),
    .ld_i           (date_ld),
    .days_i         (days3_q),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o)
  );

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

### rtl/core/sctd_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctd_date
// Day count to Gregorian year, month and day, stages four through seven.
// ----------------------------------------------------------------------------
module sctd_date (
  input  logic              clk_i,
  input  sctd_pkg::date_ld_t ld_i,
  input  logic [14:0]       days_i,
  output logic [11:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o
);
  import sctd_pkg::*;

  logic [17:0] cen_num;
  logic [34:0] cen_prod_q;
  logic [14:0] days4_q;

  logic [6:0]  cen_q5;
  logic [15:0] doy_full;
  logic [6:0]  cen5_q;
  logic [8:0]  doy5_q;

  logic [4:0]  je_cnt;
  logic [6:0]  cen6_q;
  logic [8:0]  doy6_q;
  logic [4:0]  je6_q;

  logic [8:0]  dom_full;
  logic [4:0]  mon_raw;
  logic [3:0]  mon;
  logic [11:0] yr;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  dom_q;

  // stage 4: century reciprocal multiply
  assign cen_num = {1'b0, days_i, 2'b00} + 18'(CentBias);

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      cen_prod_q <= 35'(cen_num) * 35'(CentRecip);
      days4_q    <= days_i;
    end
  end

  // stage 5: century quotient and day of the March-based year
  assign cen_q5   = cen_prod_q[CentShift +: 7];
  assign doy_full = 16'(days4_q) + 16'(DayOfYrBias) - 16'(cen_q5) * 16'(DaysPerYear)
                    - 16'(cen_q5[6:2]);

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      cen5_q <= cen_q5;
      doy5_q <= doy_full[8:0];
    end
  end

  // stage 6: month index = count of month boundaries passed
  always_comb begin
    je_cnt = '0;
    for (int e = 1; e < 17; e++) begin
      if (doy5_q > MonOff[e]) je_cnt = je_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s6) begin
      cen6_q <= cen5_q;
      doy6_q <= doy5_q;
      je6_q  <= je_cnt;
    end
  end

  // stage 7: final fields
  always_comb begin
    dom_full = doy6_q - MonOff[je6_q];
    mon_raw  = je6_q - 5'd1;
    mon      = (mon_raw > 5'd12) ? 4'(mon_raw - 5'd12) : mon_raw[3:0];
    yr       = 12'(YearBase) + 12'(cen6_q) - ((mon > 4'd2) ? 12'd1 : 12'd0);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s7) begin
      year_q  <= yr;
      month_q <= mon;
      dom_q   <= dom_full[4:0];
    end
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;

endmodule

### rtl/core/sctd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctd_checker
// Port-level checks for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
module sctd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_o
);

  // a result that waits keeps its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(year_o) && $stable(month_o)
      && $stable(day_of_month_o) && $stable(hour_o) && $stable(minute_o)
      && $stable(second_o))
    else $error("stalled result changed");

  // with the output slot empty every stage can move, so input is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input blocked while output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o >= 5'd1
      && year_o >= 12'd1989 && year_o <= 12'd2058)
    else $error("date field out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60)
    else $error("time field out of range");

endmodule

bind seconds_to_calendar_datetime_core sctd_checker u_sctd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .ready_o        (ready_o),
  .valid_o        (valid_o),
  .ready_i        (ready_i),
  .year_o         (year_o),
  .month_o        (month_o),
  .day_of_month_o (day_of_month_o),
  .hour_o         (hour_o),
  .minute_o       (minute_o),
  .second_o       (second_o)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for seconds_to_calendar_datetime_core.
// ----------------------------------------------------------------------------
// Sends timestamps through the valid/ready input channel and checks each
// converted date and time against a typed value or a behavioral Julian-day
// calculation. A short directed table covers range ends, day, month, year and
// leap-day boundaries. Random timestamps follow in four phases of source idling
// and sink stalling, with one long sink hold-off to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct packed {
    logic [30:0] secs;
    logic        typed;
    calendar_t   cal;
  } dir_row_t;

  localparam int unsigned NumDirected  = 21;
  localparam int unsigned RandPerPhase = 132;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned TailCycles   = 20;
  localparam logic [30:0] MaxSecs      = 31'h7FFF_FFFF;

  // expected value typed only for rows that read off directly
  localparam dir_row_t DirTab [NumDirected] = '{
    '{31'd0,          1'b1, '{12'd1989, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0}},
    '{31'd86399,      1'b1, '{12'd1989, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{31'd86400,      1'b1, '{12'd1990, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{31'd2147483647, 1'b1, '{12'd2058, 4'd1,  5'd18, 5'd3,  6'd14, 6'd7}},
    '{31'd1,          1'b0, '0},
    '{31'd59,         1'b0, '0},
    '{31'd60,         1'b0, '0},
    '{31'd3599,       1'b0, '0},
    '{31'd3600,       1'b0, '0},
    '{31'd43200,      1'b0, '0},
    '{31'd5184000,    1'b0, '0},   // 1990-03-01
    '{31'd68256000,   1'b0, '0},   // 1992-02-29
    '{31'd320716800,  1'b0, '0},   // 2000-02-29, century leap year
    '{31'd320803200,  1'b0, '0},
    '{31'd347155199,  1'b0, '0},   // last second of 2000-12-30
    '{31'd1073741824, 1'b0, '0},
    '{31'd1073741823, 1'b0, '0},
    '{31'd2147483646, 1'b0, '0},
    '{31'd715827882,  1'b0, '0},
    '{31'd1431655765, 1'b0, '0},
    '{31'd2146003199, 1'b0, '0}    // last second of 2057
  };

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [30:0] elapsed_seconds_i;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  calendar_t   cal_expected_q [$];
  calendar_t   offered_cal;
  int unsigned err_cnt      = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_left    = 0;
  // hold-off requests from the stimulus side, acknowledged by the sink side
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;

  seconds_to_calendar_datetime_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .ready_o          (ready_o),
    .elapsed_seconds_i(elapsed_seconds_i),
    .valid_o          (valid_o),
    .ready_i          (ready_i),
    .year_o           (year_o),
    .month_o          (month_o),
    .day_of_month_o   (day_of_month_o),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .second_o         (second_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Julian day number to Gregorian date, integer form of the classic method
  function automatic calendar_t secs_to_calendar(logic [30:0] secs);
    longint unsigned days, tod, jdn, alpha, ja, jb, jc, jd, je, mon, yr, dom;
    calendar_t       cal;
    days  = secs / 86400;
    tod   = secs % 86400;
    jdn   = days + 2447892;
    alpha = (4 * (jdn - 1867216) - 1) / 146097;
    ja    = jdn + 1 + alpha - alpha / 4;
    jb    = ja + 1524;
    jc    = 6680 + (100 * (jb - 2439870) - 12210) / 36525;
    jd    = (36525 * jc) / 100;
    je    = (10000 * (jb - jd)) / 306001;
    dom   = jb - jd - (306001 * je) / 10000;
    mon   = je - 1;
    if (mon > 12) mon -= 12;
    yr    = jc - 4715;
    if (mon > 2) yr -= 1;
    cal.year   = yr[11:0];
    cal.month  = mon[3:0];
    cal.mday   = dom[4:0];
    cal.hour   = 5'(tod / 3600);
    cal.minute = 6'((tod % 3600) / 60);
    cal.second = 6'(tod % 60);
    return cal;
  endfunction

  // mix of full-range values, whole-day offsets and day edges near both ends
  function automatic logic [30:0] pick_secs();
    longint unsigned days, tod, total;
    days = $urandom_range(24855);
    tod  = $urandom_range(86399);
    case ($urandom_range(3))
      0: return 31'($urandom());
      1: ;
      2: tod = $urandom_range(1) ? $urandom_range(2) : 86399 - $urandom_range(2);
      default: days = $urandom_range(1) ? $urandom_range(400) : 24855 - $urandom_range(400);
    endcase
    total = days * 86400 + tod;
    if (total > MaxSecs) total = MaxSecs - $urandom_range(86399);
    return total[30:0];
  endfunction

  task automatic report(string what, calendar_t want, calendar_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: exp %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d", $time,
               what, want.year, want.month, want.mday, want.hour, want.minute, want.second,
               got.year, got.month, got.mday, got.hour, got.minute, got.second);
  endtask

  task automatic send_secs(logic [30:0] secs, calendar_t cal);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i           <= 1'b1;
    elapsed_seconds_i <= secs;
    offered_cal        = cal;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (cal_expected_q.size() != 0) @(negedge clk_i);
  endtask

  // sink side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      ready_i <= 1'b0;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left    = HoldCycles - 1;
      ready_i     <= 1'b0;
    end else begin
      ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // transfer monitor: queue expectation on input, check on output
  always @(posedge clk_i) begin
    calendar_t got, want;
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        got = '{year_o, month_o, day_of_month_o, hour_o, minute_o, second_o};
        if (cal_expected_q.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = cal_expected_q.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.mday !== want.mday || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second)
            report("mismatch", want, got);
        end
      end
      if (valid_i && ready_o) cal_expected_q.push_back(offered_cal);
    end
  end

  initial begin
    logic [30:0] secs;
    rst_ni            = 1'b0;
    valid_i           = 1'b0;
    elapsed_seconds_i = '0;
    offered_cal       = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirTab[i])
      send_secs(DirTab[i].secs,
                DirTab[i].typed ? DirTab[i].cal : secs_to_calendar(DirTab[i].secs));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req_cnt++; end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        secs = pick_secs();
        send_secs(secs, secs_to_calendar(secs));
      end
      // source pauses until the pipeline is empty
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && cal_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### seconds_to_calendar_datetime_core.f
rtl/core/sctd_pkg.sv
rtl/core/sctd_date.sv
rtl/core/seconds_to_calendar_datetime_core.sv
rtl/core/sctd_checker.sv
test/tb_top.sv
